@@ rtl/core/sip_pkg.sv @@
// Shared types, constants and character helpers for the string-to-integer parser.
// Used by sip_step and string_to_integer_parse; depends on nothing else.
package sip_pkg;

  // Conversion phase
  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_LEAD   = 3'd1,
    PH_SIGN   = 3'd2,
    PH_ZERO   = 3'd3,
    PH_PREFIX = 3'd4,
    PH_DIGITS = 3'd5
  } phase_t;

  // Per-conversion state carried from one character to the next
  typedef struct packed {
    phase_t      phase;
    logic        negative;
    logic [5:0]  active_base;
    logic [31:0] accumulator;
    logic        digit_seen;
    logic        overflowed;
    logic [15:0] char_count;
  } sip_state_t;

  // One result beat
  typedef struct packed {
    logic        valid;
    logic [31:0] value;
    logic        overflow;
    logic        got_digits;
    logic [15:0] consumed;
  } sip_result_t;

  localparam logic [5:0]  RADIX_RESET = 6'd10;
  localparam logic [5:0]  BASE_AUTO   = 6'd0;
  localparam logic [5:0]  BASE_BIN    = 6'd2;
  localparam logic [5:0]  BASE_OCT    = 6'd8;
  localparam logic [5:0]  BASE_DEC    = 6'd10;
  localparam logic [5:0]  BASE_HEX    = 6'd16;
  localparam logic [15:0] COUNT_MAX   = 16'hFFFF;
  localparam logic [31:0] POS_LIMIT   = 32'h7FFF_FFFF;
  localparam logic [31:0] NEG_LIMIT   = 32'h8000_0000;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_UB    = 8'h42;
  localparam logic [7:0] CH_LB    = 8'h62;
  localparam logic [7:0] NO_DIGIT = 8'hFF;

  // Digit value of a character: 0-9, then letters 10..35, else all ones
  function automatic logic [7:0] digit_value(input logic [7:0] c);
    logic [7:0] v;
    v = NO_DIGIT;
    if (c >= CH_0 && c <= CH_9) begin
      v = c - CH_0;
    end else if (c >= CH_UA && c <= CH_UZ) begin
      v = c - (CH_UA - 8'd10);
    end else if (c >= CH_LA && c <= CH_LZ) begin
      v = c - (CH_LA - 8'd10);
    end
    return v;
  endfunction

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

endpackage

@@ rtl/core/sip_step.sv @@
// One-character step of the parser: current state and character in,
// next state and optional result out. Pure combinational; uses sip_pkg.
module sip_step (
  input  sip_pkg::sip_state_t  state,
  input  logic [7:0]           ch,
  input  logic                 first,
  input  logic [5:0]           radix,
  output sip_pkg::sip_state_t  state_next,
  output sip_pkg::sip_result_t result
);
  import sip_pkg::*;

  sip_state_t  cur;
  sip_state_t  dstate;
  logic        dfinish;
  logic [5:0]  eff_base;
  logic [7:0]  dval;
  logic        is_digit;
  logic [37:0] prod;
  logic [37:0] limit;
  logic [15:0] cnt_inc;
  logic        zero_ok;
  logic        base_any;

  always_comb begin
    // a new conversion starts from fresh state
    cur = state;
    if (first) begin
      cur.phase       = PH_LEAD;
      cur.negative    = 1'b0;
      cur.active_base = radix;
      cur.accumulator = '0;
      cur.digit_seen  = 1'b0;
      cur.overflowed  = 1'b0;
      cur.char_count  = '0;
    end

    base_any = (cur.active_base == BASE_AUTO);

    // base used if this character goes to the digit step
    case (cur.phase)
      PH_ZERO: eff_base = base_any ? BASE_OCT : cur.active_base;
      default: eff_base = base_any ? BASE_DEC : cur.active_base;
    endcase

    // digit multiply-add and range check
    dval     = digit_value(ch);
    is_digit = dval < {2'b00, eff_base};
    prod     = 38'(cur.accumulator) * 38'(eff_base) + 38'(dval);
    limit    = cur.negative ? 38'(NEG_LIMIT) : 38'(POS_LIMIT);
    cnt_inc  = (cur.char_count == COUNT_MAX) ? cur.char_count : cur.char_count + 16'd1;

    // digit step outcome
    dstate             = cur;
    dstate.active_base = eff_base;
    dfinish            = 1'b0;
    if (!is_digit) begin
      dstate.phase = PH_IDLE;
      dfinish      = 1'b1;
    end else begin
      if (!cur.overflowed) begin
        if (prod > limit) begin
          dstate.overflowed = 1'b1;
        end else begin
          dstate.accumulator = prod[31:0];
        end
      end
      dstate.digit_seen = 1'b1;
      dstate.phase      = PH_DIGITS;
      dstate.char_count = cnt_inc;
    end

    zero_ok = (ch == CH_0) &&
              (base_any || cur.active_base == BASE_HEX || cur.active_base == BASE_BIN);

    // phase dispatch
    state_next   = cur;
    result.valid = 1'b0;
    case (cur.phase)
      PH_LEAD, PH_SIGN: begin
        if (cur.phase == PH_LEAD && is_ws(ch)) begin
          state_next.char_count = cnt_inc;
        end else if (cur.phase == PH_LEAD && (ch == CH_MINUS || ch == CH_PLUS)) begin
          state_next.negative   = (ch == CH_MINUS);
          state_next.phase      = PH_SIGN;
          state_next.char_count = cnt_inc;
        end else if (zero_ok) begin
          state_next.accumulator = '0;
          state_next.digit_seen  = 1'b1;
          state_next.phase       = PH_ZERO;
          state_next.char_count  = cnt_inc;
        end else begin
          state_next   = dstate;
          result.valid = dfinish;
        end
      end
      PH_ZERO: begin
        if ((ch == CH_LX || ch == CH_UX) && (base_any || cur.active_base == BASE_HEX)) begin
          state_next.active_base = BASE_HEX;
          state_next.digit_seen  = 1'b0;
          state_next.phase       = PH_PREFIX;
          state_next.char_count  = cnt_inc;
        end else if ((ch == CH_LB || ch == CH_UB) &&
                     (base_any || cur.active_base == BASE_BIN)) begin
          state_next.active_base = BASE_BIN;
          state_next.digit_seen  = 1'b0;
          state_next.phase       = PH_PREFIX;
          state_next.char_count  = cnt_inc;
        end else begin
          state_next   = dstate;
          result.valid = dfinish;
        end
      end
      PH_PREFIX, PH_DIGITS: begin
        state_next   = dstate;
        result.valid = dfinish;
      end
      default: begin
        state_next.phase = PH_IDLE;
      end
    endcase

    // result fields come from the state before the terminator
    if (cur.overflowed) begin
      result.value = cur.negative ? NEG_LIMIT : POS_LIMIT;
    end else begin
      result.value = cur.negative ? (32'd0 - cur.accumulator) : cur.accumulator;
    end
    result.overflow   = cur.overflowed;
    result.got_digits = cur.digit_seen;
    result.consumed   = cur.digit_seen ? cur.char_count : 16'd0;
  end

endmodule

@@ rtl/core/string_to_integer_parse.sv @@
// Flow: a character beat accepted into the input register is parsed by sip_step once the
// output is free; a terminator's result beat is then registered in the result register.
// Throughput: one character per cycle while the output is not held, set by the
// combinational multiply-add loop on the accumulator. Reset: rst (synchronous) empties both
// registers, returns the parser to idle and sets radix to 10. Uses sip_pkg and sip_step.
module string_to_integer_parse (
  input  logic        clk,
  input  logic        rst,
  // configuration: radix
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [5:0]  cfg_data,
  // character input
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] ch
  input  logic [0:0]  s_axis_tuser,   // [0] first
  // result output
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata    // [31:0] value, [32] overflow, [33] got_digits,
                                      // [49:34] consumed, [55:50] zero
);
  import sip_pkg::*;

  logic [5:0]  radix_q;
  logic        in_valid;
  logic [7:0]  in_ch;
  logic        in_first;
  logic        out_free;
  logic        consume;
  sip_state_t  state;
  sip_state_t  state_next;
  sip_result_t result;

  assign cfg_ready = 1'b1;

  // radix register
  always_ff @(posedge clk) begin
    if (rst) begin
      radix_q <= RADIX_RESET;
    end else if (cfg_valid) begin
      radix_q <= cfg_data;
    end
  end

  // input register
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign consume       = in_valid && out_free;
  assign s_axis_tready = !in_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_ch    <= s_axis_tdata;
      in_first <= s_axis_tuser[0];
    end
  end

  // character step
  sip_step u_step (
    .state      (state),
    .ch         (in_ch),
    .first      (in_first),
    .radix      (radix_q),
    .state_next (state_next),
    .result     (result)
  );

  // conversion state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (consume) begin
      state <= state_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (consume && result.valid) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (consume && result.valid) begin
      m_axis_tdata <= {6'd0, result.consumed, result.got_digits, result.overflow,
                       result.value};
    end
  end

  // a terminator always ends the conversion
  a_finish_idle: assert property (@(posedge clk) disable iff (rst)
    consume && result.valid |=> state.phase == PH_IDLE)
    else $error("parser not idle after result");

  // without digits the result is all zero
  a_no_digits: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[33] |->
      m_axis_tdata[49:34] == 16'd0 && !m_axis_tdata[32] && m_axis_tdata[31:0] == 32'd0)
    else $error("nonzero result without digits");

  // overflow saturates
  a_sat: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[32] |->
      m_axis_tdata[31:0] == POS_LIMIT || m_axis_tdata[31:0] == NEG_LIMIT)
    else $error("overflow value not saturated");

  // input stalls only behind a held result
  a_stall: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> in_valid && m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without cause");

endmodule
